// ===== hdl/acc_pkg.sv =====
// Package for the ASCII command controller: controller states, reply kinds,
// text segments and the reply-text character functions. No dependencies.
package acc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEND
    } t_state;

    typedef enum logic [3:0] {
        RK_OK,
        RK_ER,
        RK_QT,
        RK_QA,
        RK_QI,
        RK_QR,
        RK_RB,
        RK_RN,
        RK_RS,
        RK_RP
    } t_kind;

    typedef enum logic [3:0] {
        SG_OK,
        SG_ER,
        SG_THI,
        SG_TLO,
        SG_QA,
        SG_QI,
        SG_BHDR,
        SG_BTXT,
        SG_NHDR,
        SG_NDIG,
        SG_SHDR,
        SG_STXT,
        SG_PHDR,
        SG_PTXT
    } t_seg;

    // Header texts, stored last character first.
    localparam logic [47:0] TxtBaud  = " :DUAB";
    localparam logic [63:0] TxtNbits = " :STIB_N";
    localparam logic [47:0] TxtStop  = " :POTS";
    localparam logic [63:0] TxtPar   = " :YTIRAP";

    typedef struct packed {
        logic load;
        logic exec;
        logic advance;
    } t_ctrl;

    typedef struct packed {
        logic       done;
        logic [7:0] ch;
        logic       last;
    } t_stat;

    // Character k of a baud text (code 0..9); shorter texts are padded with spaces.
    function automatic logic [7:0] baud_ch(input logic [3:0] c, input logic [2:0] k);
        logic [55:0] s;
        begin
            case (c)
                4'd0: s = {"   ", " 003"};
                4'd1: s = {"  ", " 0021"};
                4'd2: s = {"  ", " 0042"};
                4'd3: s = {"  ", " 0084"};
                4'd4: s = {"  ", " 0069"};
                4'd5: s = {" ", " 00291"};
                4'd6: s = {" ", " 00483"};
                4'd7: s = {" ", " 00675"};
                4'd8: s = " 002511";
                default: s = " 004032";
            endcase
            baud_ch = s[k*8 +: 8];
        end
    endfunction

    function automatic logic [2:0] baud_len(input logic [3:0] c);
        begin
            case (c)
                4'd0: baud_len = 3'd4;
                4'd1, 4'd2, 4'd3, 4'd4: baud_len = 3'd5;
                4'd5, 4'd6, 4'd7: baud_len = 3'd6;
                default: baud_len = 3'd7;
            endcase
        end
    endfunction

    // Character k of a stop text (code 2..4).
    function automatic logic [7:0] stop_ch(input logic [2:0] c, input logic [1:0] k);
        logic [31:0] s;
        begin
            case (c)
                3'd3: s = " 5.1";
                3'd4: s = {16'd0, " 2"};
                default: s = {16'd0, " 1"};
            endcase
            stop_ch = s[{k, 3'b000} +: 8];
        end
    endfunction

    function automatic logic [2:0] stop_len(input logic [2:0] c);
        begin
            case (c)
                3'd3: stop_len = 3'd4;
                default: stop_len = 3'd2;
            endcase
        end
    endfunction

    // Character k of a parity text (code 0..4).
    function automatic logic [7:0] par_ch(input logic [2:0] c, input logic [2:0] k);
        logic [47:0] s;
        begin
            case (c)
                3'd0: s = {8'd0, " NEVE"};
                3'd1: s = {16'd0, " DDO"};
                3'd2: s = {8'd0, " KRAM"};
                3'd3: s = " ECAPS";
                default: s = {8'd0, " ENON"};
            endcase
            par_ch = s[{k, 3'b000} +: 8];
        end
    endfunction

    function automatic logic [2:0] par_len(input logic [2:0] c);
        begin
            case (c)
                3'd1: par_len = 3'd4;
                3'd3: par_len = 3'd6;
                default: par_len = 3'd5;
            endcase
        end
    endfunction

endpackage

// ===== hdl/ascii_command_controller.sv =====
// ASCII command controller top level: controller FSM plus datapath.
// Depends on acc_pkg, acc_controller, acc_datapath.
//
// Input channel s_axis: one beat per three-byte command.
// Output channel m_axis: one beat per reply character, tlast on the last.
// A command is taken only when the previous reply has been fully sent.
// The first character is offered in the send state, entered after the decode state.
// Reply length is 2..46 characters, generated one character per cycle from
// the reply segments while the receiver is ready.
// Reset (synchronous, active low) returns all switches and actuators to 0,
// setpoint to 16 and serial settings to their defaults; reply is dropped.
// When the receiver stalls, the current character holds until taken.
module ascii_command_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // opcode, first_arg, second_arg
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_char
    output logic        m_axis_tlast   // last_char
);
    acc_pkg::t_ctrl ctrl;
    acc_pkg::t_stat stat;

    acc_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_ctrl(ctrl)
    );

    acc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(s_axis_tdata),
        .i_ctrl(ctrl), .o_stat(stat)
    );

    assign m_axis_tdata = stat.ch;
    assign m_axis_tlast = stat.last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("accept during reply");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("no return to idle");
    a_reply_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("reply missing");
endmodule

// ===== hdl/acc_datapath.sv =====
// Datapath: state registers and reply sequencer. Latches the reply kind on a
// decode beat and walks its text segments one character per advance.
// Depends on acc_pkg.
module acc_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [23:0]   i_cmd,
    input  acc_pkg::t_ctrl i_ctrl,
    output acc_pkg::t_stat o_stat
);
    logic [7:0]  r_sw;
    logic [3:0]  r_act [10];
    logic [7:0]  r_therm;
    logic [3:0]  r_baud, r_nbits;
    logic [2:0]  r_stop, r_par;
    logic [23:0] r_cmd;
    acc_pkg::t_kind r_kind;
    logic [2:0]  r_seg, r_off;

    logic [7:0] op, a1, a2, d1, d2;
    assign op = r_cmd[7:0];
    assign a1 = r_cmd[15:8];
    assign a2 = r_cmd[23:16];
    assign d1 = (a1 < 8'd48) ? 8'hFF : a1 - 8'd48;
    assign d2 = (a2 < 8'd48) ? 8'hFF : a2 - 8'd48;

    acc_pkg::t_kind w_kind;
    logic w_sw, w_act, w_th, w_baud, w_nb, w_stop, w_par;

    always_comb begin
        w_kind = acc_pkg::RK_ER;
        {w_sw, w_act, w_th, w_baud, w_nb, w_stop, w_par} = '0;
        if (op == "I") begin
            if (d1 <= 8'd7 && d2 <= 8'd1) begin
                w_sw = 1'b1; w_kind = acc_pkg::RK_OK;
            end
        end else if (op == "A") begin
            if (d1 <= 8'd9 && d2 <= 8'd9) begin
                w_act = 1'b1; w_kind = acc_pkg::RK_OK;
            end
        end else if (op == "T") begin
            if (a1 >= "1" && a1 <= "2" && d2 <= 8'd207) begin
                w_th = 1'b1; w_kind = acc_pkg::RK_OK;
            end
        end else if (op == "S") begin
            case (a1)
                "T": w_kind = acc_pkg::RK_QT;
                "A": if (d2 <= 8'd9) w_kind = acc_pkg::RK_QA;
                "I": if (d2 <= 8'd7) w_kind = acc_pkg::RK_QI;
                "R": w_kind = acc_pkg::RK_QR;
                default: ;
            endcase
        end else if (op == "R") begin
            case (a1)
                "9": if (d2 <= 8'd9) begin
                    w_baud = 1'b1; w_kind = acc_pkg::RK_RB;
                end
                "8": if (d2 >= 8'd5 && d2 <= 8'd8) begin
                    w_nb = 1'b1; w_kind = acc_pkg::RK_RN;
                end
                "7": if (d2 >= 8'd2 && d2 <= 8'd4) begin
                    w_stop = 1'b1; w_kind = acc_pkg::RK_RS;
                end
                "6": if (d2 <= 8'd4) begin
                    w_par = 1'b1; w_kind = acc_pkg::RK_RP;
                end
                default: ;
            endcase
        end
    end

    // Segment list of each reply; setting replies read the freshly written
    // registers, so they share the report segments.
    acc_pkg::t_seg w_seg;
    logic          w_fin;

    always_comb begin
        w_seg = acc_pkg::SG_ER;
        w_fin = 1'b1;
        case (r_kind)
            acc_pkg::RK_OK: w_seg = acc_pkg::SG_OK;
            acc_pkg::RK_QT: begin
                if (r_seg == 3'd0) begin
                    w_seg = acc_pkg::SG_THI; w_fin = 1'b0;
                end else begin
                    w_seg = acc_pkg::SG_TLO;
                end
            end
            acc_pkg::RK_QA: w_seg = acc_pkg::SG_QA;
            acc_pkg::RK_QI: w_seg = acc_pkg::SG_QI;
            acc_pkg::RK_QR: begin
                w_fin = 1'b0;
                case (r_seg)
                    3'd0: w_seg = acc_pkg::SG_BHDR;
                    3'd1: w_seg = acc_pkg::SG_BTXT;
                    3'd2: w_seg = acc_pkg::SG_NHDR;
                    3'd3: w_seg = acc_pkg::SG_NDIG;
                    3'd4: w_seg = acc_pkg::SG_SHDR;
                    3'd5: w_seg = acc_pkg::SG_STXT;
                    3'd6: w_seg = acc_pkg::SG_PHDR;
                    default: begin w_seg = acc_pkg::SG_PTXT; w_fin = 1'b1; end
                endcase
            end
            acc_pkg::RK_RB, acc_pkg::RK_RN, acc_pkg::RK_RS, acc_pkg::RK_RP: begin
                w_fin = 1'b0;
                case (r_seg)
                    3'd0: begin
                        case (r_kind)
                            acc_pkg::RK_RB: w_seg = acc_pkg::SG_BHDR;
                            acc_pkg::RK_RN: w_seg = acc_pkg::SG_NHDR;
                            acc_pkg::RK_RS: w_seg = acc_pkg::SG_SHDR;
                            default: w_seg = acc_pkg::SG_PHDR;
                        endcase
                    end
                    3'd1: begin
                        case (r_kind)
                            acc_pkg::RK_RB: w_seg = acc_pkg::SG_BTXT;
                            acc_pkg::RK_RN: w_seg = acc_pkg::SG_NDIG;
                            acc_pkg::RK_RS: w_seg = acc_pkg::SG_STXT;
                            default: w_seg = acc_pkg::SG_PTXT;
                        endcase
                    end
                    default: begin w_seg = acc_pkg::SG_OK; w_fin = 1'b1; end
                endcase
            end
            default: w_seg = acc_pkg::SG_ER;
        endcase
    end

    logic [7:0] w_ch;
    logic [3:0] w_len;
    logic       w_end;
    logic [3:0] hn, ln;
    assign hn = r_therm[7:4];
    assign ln = r_therm[3:0];

    always_comb begin
        w_ch  = 8'd0;
        w_len = 4'd1;
        case (w_seg)
            acc_pkg::SG_OK: begin
                w_len = 4'd2; w_ch = (r_off == 3'd0) ? "O" : "K";
            end
            acc_pkg::SG_ER: begin
                w_len = 4'd2; w_ch = (r_off == 3'd0) ? "E" : "R";
            end
            acc_pkg::SG_THI: begin
                if (hn >= 4'd10) begin
                    w_len = 4'd2;
                    w_ch  = (r_off == 3'd0) ? "1" : 8'd48 + {4'd0, hn - 4'd10};
                end else begin
                    w_len = 4'd1; w_ch = 8'd48 + {4'd0, hn};
                end
            end
            acc_pkg::SG_TLO: begin
                if (ln >= 4'd10) begin
                    w_len = 4'd2;
                    w_ch  = (r_off == 3'd0) ? "1" : 8'd48 + {4'd0, ln - 4'd10};
                end else begin
                    w_len = 4'd1; w_ch = 8'd48 + {4'd0, ln};
                end
            end
            acc_pkg::SG_QA: begin
                w_len = 4'd2;
                w_ch  = (r_off == 3'd0) ? "A" : 8'd48 + {4'd0, r_act[d2[3:0]]};
            end
            acc_pkg::SG_QI: begin
                w_len = 4'd2;
                w_ch  = (r_off == 3'd0) ? "I" : 8'd48 + {7'd0, r_sw[d2[2:0]]};
            end
            acc_pkg::SG_BHDR: begin
                w_len = 4'd6; w_ch = acc_pkg::TxtBaud[{r_off, 3'b000} +: 8];
            end
            acc_pkg::SG_BTXT: begin
                w_len = {1'b0, acc_pkg::baud_len(r_baud)};
                w_ch  = acc_pkg::baud_ch(r_baud, r_off);
            end
            acc_pkg::SG_NHDR: begin
                w_len = 4'd8; w_ch = acc_pkg::TxtNbits[{r_off, 3'b000} +: 8];
            end
            acc_pkg::SG_NDIG: begin
                w_len = 4'd1; w_ch = 8'd48 + {4'd0, r_nbits};
            end
            acc_pkg::SG_SHDR: begin
                w_len = 4'd6; w_ch = acc_pkg::TxtStop[{r_off, 3'b000} +: 8];
            end
            acc_pkg::SG_STXT: begin
                w_len = {1'b0, acc_pkg::stop_len(r_stop)};
                w_ch  = acc_pkg::stop_ch(r_stop, r_off[1:0]);
            end
            acc_pkg::SG_PHDR: begin
                w_len = 4'd8; w_ch = acc_pkg::TxtPar[{r_off, 3'b000} +: 8];
            end
            acc_pkg::SG_PTXT: begin
                w_len = {1'b0, acc_pkg::par_len(r_par)};
                w_ch  = acc_pkg::par_ch(r_par, r_off);
            end
            default: begin
                w_len = 4'd1; w_ch = 8'd0;
            end
        endcase
    end

    assign w_end = ({1'b0, r_off} + 4'd1 == w_len);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) r_cmd <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '0;
            for (int i = 0; i < 10; i++) r_act[i] <= '0;
            r_therm <= 8'd16;
            r_baud  <= 4'd8;
            r_nbits <= 4'd8;
            r_stop  <= 3'd2;
            r_par   <= 3'd4;
            r_kind  <= acc_pkg::RK_ER;
            r_seg   <= '0;
            r_off   <= '0;
        end else begin
            if (i_ctrl.exec) begin
                r_kind <= w_kind;
                r_seg  <= '0;
                r_off  <= '0;
                if (w_sw)   r_sw[d1[2:0]] <= d2[0];
                if (w_act)  r_act[d1[3:0]] <= d2[3:0];
                if (w_th)   r_therm <= {d1[3:0], 4'd0} + d2;
                if (w_baud) r_baud <= d2[3:0];
                if (w_nb)   r_nbits <= d2[3:0];
                if (w_stop) r_stop <= d2[2:0];
                if (w_par)  r_par <= d2[2:0];
            end else if (i_ctrl.advance) begin
                if (w_end) begin
                    r_seg <= r_seg + 1'b1;
                    r_off <= '0;
                end else begin
                    r_off <= r_off + 1'b1;
                end
            end
        end
    end

    assign o_stat.ch   = w_ch;
    assign o_stat.last = w_fin && w_end;
    assign o_stat.done = o_stat.last;
endmodule

// ===== hdl/acc_controller.sv =====
// Controller FSM: accepts a command, triggers decode, streams the reply.
// Depends on acc_pkg.
module acc_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  acc_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output acc_pkg::t_ctrl o_ctrl
);
    acc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= acc_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl      = '0;
        case (r_state)
            acc_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
                if (i_in_valid) n_state = acc_pkg::ST_DECODE;
            end
            acc_pkg::ST_DECODE: begin
                o_ctrl.exec = 1'b1;
                n_state     = acc_pkg::ST_SEND;
            end
            acc_pkg::ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_ctrl.advance = 1'b1;
                    if (i_stat.done) n_state = acc_pkg::ST_IDLE;
                end
            end
            default: n_state = acc_pkg::ST_IDLE;
        endcase
    end
endmodule
